@@ rtl/core/dpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants for the detection precision curve block.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int unsigned SCORE_W = 32;
  localparam int unsigned PREC_W  = 17;
  localparam int unsigned NP_W    = 7;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned QBITS   = 16;

  // most negative Q16.16 score, initial best score of every truth point
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // register indexes
  localparam logic [0:0] REG_NUM_POINTS = 1'b0;

  typedef logic signed [SCORE_W-1:0] score_t;

endpackage

@@ rtl/core/detection_precision_curve_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_precision_curve_top
// Tracks best score per truth point and stores unmatched scores; on the last
// item sorts best scores, counts unmatched scores above each, emits precision.
// ----------------------------------------------------------------------------
// channel | ports                                   | handshake
// input   | in_score, in_matched, in_point_index,   | start & !busy
//         | in_last                                 |
// result  | out_rank_index, out_precision,          | out_valid, one cycle
//         | out_last_result                         |
// config  | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// Load: each item takes a memory read, then a modify/write back of the
// best-score memory. After the last item, each truth point in use is read
// from the best-score RAM and then inserted into a sorted shift array; then
// per rank one pass over the unmatched store (bounded by the RAM read port),
// restoring division (a setup step plus 24 quotient bits) and an emit step.
// busy is high throughout; the receiver cannot stall. Reset: synchronous,
// active low; the store needs no clearing.
// ----------------------------------------------------------------------------
module detection_precision_curve_top #(
  parameter int unsigned MAX_POINTS     = 64,
  parameter int unsigned MAX_DETECTIONS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  dpc_pkg::score_t             in_score,
  input  logic                        in_matched,
  input  logic [5:0]                  in_point_index,
  input  logic                        in_last,
  output logic                        out_valid,
  output logic [5:0]                  out_rank_index,
  output logic [16:0]                 out_precision,
  output logic                        out_last_result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import dpc_pkg::*;

  localparam int unsigned PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DW = $clog2(MAX_DETECTIONS);
  localparam int unsigned CW = DW + 1;
  localparam int unsigned DENW = CW + 1;
  localparam int unsigned NUMW = PW + 1 + QBITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD_WR, S_SORT, S_COUNT, S_DIV, S_EMIT
  } state_t;

  state_t                  state_r;
  logic [NP_W-1:0]         num_points_r;
  logic [PW:0]             n_eff_r;
  score_t                  score_r;
  logic                    matched_r, last_r;
  logic [PW-1:0]           idx_r;
  logic                    idx_ok_r;

  // best score memory with per-entry valid bits (cleared after each run)
  score_t                  best_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0]   best_vld_r;
  score_t                  best_rd_r;
  logic                    best_rd_vld_r;

  // unmatched score store
  score_t                  um_mem [MAX_DETECTIONS];
  score_t                  um_rd_r;
  logic [CW-1:0]           um_cnt_r;

  // sorted best scores, insertion into a shift array
  score_t                  srt_r [MAX_POINTS];
  logic [PW:0]             sidx_r;
  logic                    sphase_r;

  logic [PW:0]             rank_r;
  logic [CW-1:0]           jcnt_r;
  logic [CW-1:0]           fp_r;
  logic                    cmp_pend_r;

  logic [NUMW-1:0]         rem_r;
  logic [QBITS+PW+1:0]     quo_r;
  logic [DENW-1:0]         den_r;
  logic [5:0]              dcnt_r;

  logic                    accept;
  logic [NP_W-1:0]         np_clamp;
  score_t                  best_cur;
  score_t                  srt_cur;

  assign pready = 1'b1;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (num_points_r == '0) np_clamp = NP_W'(1);
    else if (num_points_r > NP_W'(MAX_POINTS)) np_clamp = NP_W'(MAX_POINTS);
    else np_clamp = num_points_r;
  end

  always_comb begin
    prdata = '0;
    if (paddr == 2'(REG_NUM_POINTS)) prdata = 32'(num_points_r);
  end

  assign best_cur = best_rd_vld_r ? best_rd_r : SCORE_MIN;
  // current rank always sits at the head of the sorted array
  assign srt_cur  = srt_r[0];

  // best score memory port
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      best_rd_r     <= best_mem[in_point_index[PW-1:0]];
    end else if (state_r == S_SORT) begin
      best_rd_r     <= best_mem[sidx_r[PW-1:0]];
    end
    if (state_r == S_LOAD_WR && matched_r && idx_ok_r && score_r > best_cur) begin
      best_mem[idx_r] <= score_r;
    end
  end

  // unmatched store port
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD_WR && !matched_r && um_cnt_r < CW'(MAX_DETECTIONS)) begin
      um_mem[um_cnt_r[DW-1:0]] <= score_r;
    end
    um_rd_r <= um_mem[jcnt_r[DW-1:0]];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      num_points_r  <= NP_W'(64);
      best_vld_r    <= '0;
      best_rd_vld_r <= 1'b0;
      um_cnt_r      <= '0;
      out_valid     <= 1'b0;
      sidx_r        <= '0;
      sphase_r      <= 1'b0;
      rank_r        <= '0;
      jcnt_r        <= '0;
      cmp_pend_r    <= 1'b0;
      dcnt_r        <= '0;
    end else begin
      out_valid <= 1'b0;
      if (psel && penable && pwrite && paddr == 2'(REG_NUM_POINTS))
        num_points_r <= pwdata[NP_W-1:0];
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            score_r       <= in_score;
            matched_r     <= in_matched;
            last_r        <= in_last;
            idx_r         <= in_point_index[PW-1:0];
            idx_ok_r      <= (NP_W'(in_point_index) < np_clamp);
            best_rd_vld_r <= best_vld_r[in_point_index[PW-1:0]];
            n_eff_r       <= (PW+1)'(np_clamp);
            state_r       <= S_LOAD_WR;
          end
        end
        S_LOAD_WR: begin
          if (matched_r && idx_ok_r && score_r > best_cur)
            best_vld_r[idx_r] <= 1'b1;
          if (!matched_r && um_cnt_r < CW'(MAX_DETECTIONS))
            um_cnt_r <= um_cnt_r + 1'b1;
          if (last_r) begin
            sidx_r   <= '0;
            sphase_r <= 1'b0;
            state_r  <= S_SORT;
          end else begin
            state_r  <= S_IDLE;
          end
        end
        S_SORT: begin
          // phase 0: read entry sidx; phase 1: insert it
          if (!sphase_r) begin
            best_rd_vld_r <= (sidx_r < (PW+1)'(MAX_POINTS)) ?
                             best_vld_r[sidx_r[PW-1:0]] : 1'b0;
            sphase_r <= 1'b1;
          end else begin
            for (int k = MAX_POINTS-1; k >= 0; k--) begin
              if ((PW+1)'(k) <= sidx_r) begin
                if (k > 0 && (PW+1)'(k) <= sidx_r && srt_r[k-1 < 0 ? 0 : k-1] > best_cur
                    && k != 0)
                  srt_r[k] <= srt_r[k-1 < 0 ? 0 : k-1];
                else if (k == 0 || !(srt_r[k-1 < 0 ? 0 : k-1] > best_cur))
                  srt_r[k] <= ((PW+1)'(k) == sidx_r || srt_r[k] > best_cur) ?
                              best_cur : srt_r[k];
              end
            end
            sphase_r <= 1'b0;
            if (sidx_r + 1'b1 == n_eff_r) begin
              best_vld_r <= '0;
              rank_r     <= '0;
              jcnt_r     <= '0;
              fp_r       <= '0;
              cmp_pend_r <= 1'b0;
              state_r    <= S_COUNT;
            end
            sidx_r <= sidx_r + 1'b1;
          end
        end
        S_COUNT: begin
          // read stream: um_rd_r holds entry jcnt-1 when cmp_pend_r
          if (cmp_pend_r && um_rd_r > srt_cur) fp_r <= fp_r + 1'b1;
          if (jcnt_r < um_cnt_r) begin
            jcnt_r     <= jcnt_r + 1'b1;
            cmp_pend_r <= 1'b1;
          end else begin
            cmp_pend_r <= 1'b0;
            state_r    <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_r == '0 && !cmp_pend_r) begin
            rem_r      <= NUMW'({rank_r + 1'b1, {QBITS{1'b0}}}) +
                          NUMW'((rank_r + CW'(0) + fp_r + 1'b1) >> 1);
            den_r      <= DENW'(rank_r) + DENW'(fp_r) + 1'b1;
            quo_r      <= '0;
            dcnt_r     <= 6'(NUMW);
            cmp_pend_r <= 1'b1;
          end else if (dcnt_r != '0) begin
            // restoring division, one quotient bit per cycle
            if ((rem_r >> (dcnt_r - 1'b1)) >= NUMW'(den_r)) begin
              rem_r <= rem_r - (NUMW'(den_r) << (dcnt_r - 1'b1));
              quo_r <= (quo_r << 1) | 1'b1;
            end else begin
              quo_r <= quo_r << 1;
            end
            dcnt_r <= dcnt_r - 1'b1;
            if (dcnt_r == 6'd1) state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_valid       <= 1'b1;
          out_rank_index  <= RANK_W'(rank_r);
          out_precision   <= quo_r[PREC_W-1:0];
          out_last_result <= (rank_r + 1'b1 == n_eff_r);
          cmp_pend_r      <= 1'b0;
          dcnt_r          <= '0;
          if (rank_r + 1'b1 == n_eff_r) begin
            um_cnt_r <= '0;
            state_r  <= S_IDLE;
          end else begin
            // move the next rank to the head
            for (int k = 0; k < MAX_POINTS-1; k++)
              srt_r[k] <= srt_r[k+1];
            rank_r  <= rank_r + 1'b1;
            jcnt_r  <= '0;
            fp_r    <= '0;
            state_r <= S_COUNT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept) else $error("accept while busy");
  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_EMIT) else $error("strobe outside emit");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    um_cnt_r <= CW'(MAX_DETECTIONS)) else $error("unmatched count overflow");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |=>
      ((state_r == S_IDLE || state_r == S_LOAD_WR) && um_cnt_r == '0))
    else $error("run not cleared");

endmodule

@@ tb/tb_detection_precision_curve_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_precision_curve_top
// Self-checking bench for the precision curve block: drives scored detection
// runs, predicts the per-rank precision items and compares each output item.
// ----------------------------------------------------------------------------
module tb_detection_precision_curve_top;
  import dpc_pkg::*;

  localparam int MAXP = 64;
  localparam int MAXD = 1024;
  localparam int WDOG_LIMIT = 2000000;

  typedef struct packed {
    logic [5:0]  rank;
    logic [16:0] prec;
    logic        lst;
  } curve_item_t;

  typedef struct {
    logic [31:0] score;
    logic        matched;
    logic [5:0]  idx;
    logic        lst;
    int          np_cfg;   // -1: keep register as is, else write before item
    int          exp_prec; // -1: predictor, else the single-rank curve value
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  score_t      in_score = '0;
  logic        in_matched = 1'b0;
  logic [5:0]  in_point_index = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic [5:0]  out_rank_index;
  logic [16:0] out_precision;
  logic        out_last_result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  score_t      best_tbl [MAXP];
  score_t      fp_store [MAXD];
  int          fp_cnt;
  logic [6:0]  np_reg;

  curve_item_t curve_q [$];
  int          mism = 0;
  int          wdog = 0;
  bit          failed = 1'b0;

  always #5 clk = ~clk;

  detection_precision_curve_top u_dut (
    .clk, .rst_n, .start, .busy, .in_score, .in_matched, .in_point_index,
    .in_last, .out_valid, .out_rank_index, .out_precision, .out_last_result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  function automatic void clear_run();
    for (int i = 0; i < MAXP; i++) best_tbl[i] = SCORE_MIN;
    fp_cnt = 0;
  endfunction

  // load one detection; on last, queue the whole curve
  function automatic void predict_curve(logic [31:0] s, logic m, logic [5:0] ix, logic l);
    int n;
    score_t srt [MAXP];
    score_t v;
    int j;
    int cnt;
    longint unsigned num, den;
    curve_item_t it;
    n = (np_reg < 1) ? 1 : (np_reg > MAXP) ? MAXP : np_reg;
    if (m) begin
      if (ix < n && $signed(s) > best_tbl[ix]) best_tbl[ix] = s;
    end else if (fp_cnt < MAXD) begin
      fp_store[fp_cnt] = s;
      fp_cnt++;
    end
    if (!l) return;
    for (int i = 0; i < n; i++) begin
      v = best_tbl[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    for (int i = 0; i < n; i++) begin
      cnt = 0;
      for (int k = 0; k < fp_cnt; k++) if (fp_store[k] > srt[i]) cnt++;
      num = longint'(i + 1) << 16;
      den = i + cnt + 1;
      it.rank = i[5:0];
      it.prec = 17'((num + den / 2) / den);
      it.lst = (i + 1 == n);
      curve_q = {curve_q, it};
    end
    clear_run();
  endfunction

  // output checker and watchdog
  always @(posedge clk) begin
    curve_item_t exp_it;
    if (rst_n) begin
      if ((start && !busy) || out_valid) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
    if (out_valid) begin
      if (curve_q.size() == 0) begin
        failed = 1'b1;
        mism++;
        if (mism <= 10) $display("unexpected item rank=%0d", out_rank_index);
      end else begin
        exp_it = curve_q.pop_front();
        if (exp_it.rank !== out_rank_index || exp_it.prec !== out_precision ||
            exp_it.lst !== out_last_result) begin
          failed = 1'b1;
          mism++;
          if (mism <= 10)
            $display("mismatch exp rank=%0d prec=%0d last=%0b got %0d %0d %0b",
                     exp_it.rank, exp_it.prec, exp_it.lst,
                     out_rank_index, out_precision, out_last_result);
        end
      end
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // two-phase register write, only while idle
  task automatic write_num_points(logic [6:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {REG_NUM_POINTS, 1'b0} << 1; pwdata = 32'(v);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    np_reg = v;
  endtask

  // wait for the curve to drain, then for the block to drop busy
  task automatic drain();
    while (curve_q.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    idle_cycles(4);
  endtask

  task automatic send_detection(logic [31:0] s, logic m, logic [5:0] ix, logic l);
    idle_cycles($urandom_range(0, 6));
    in_score = s; in_matched = m; in_point_index = ix; in_last = l;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_curve(s, m, ix, l);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [31:0] rand_score();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 400)) - 200) <<< 14;
    endcase
  endfunction

  stim_row_t dir_tbl [$];

  initial begin
    int np;
    int len;
    logic [31:0] s;
    curve_item_t typed;
    clear_run();
    np_reg = 7'd64;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, ignored index, clamped counts
    dir_tbl = '{
      '{32'h8000_0000, 1'b0, 6'd0,  1'b0, 1,   -1},
      '{32'h7fff_ffff, 1'b1, 6'd0,  1'b1, -1,  65536},
      '{32'h0001_0000, 1'b1, 6'd5,  1'b1, 0,   65536},
      '{32'h7fff_ffff, 1'b0, 6'd0,  1'b0, 4,   -1},
      '{32'h8000_0000, 1'b1, 6'd1,  1'b0, -1,  -1},
      '{32'h0000_0000, 1'b1, 6'd2,  1'b0, -1,  -1},
      '{32'h0002_0000, 1'b1, 6'd9,  1'b0, -1,  -1},
      '{32'hffff_0000, 1'b0, 6'd63, 1'b0, -1,  -1},
      '{32'h0000_0000, 1'b1, 6'd3,  1'b1, -1,  -1},
      '{32'h7fff_ffff, 1'b1, 6'd63, 1'b0, 127, -1},
      '{32'h1234_5678, 1'b0, 6'd0,  1'b0, -1,  -1},
      '{32'h8000_0001, 1'b1, 6'd32, 1'b1, -1,  -1},
      '{32'h0000_0001, 1'b1, 6'd0,  1'b1, 64,  -1}
    };
    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].np_cfg >= 0) begin
        drain();
        write_num_points(7'(dir_tbl[k].np_cfg));
      end
      send_detection(dir_tbl[k].score, dir_tbl[k].matched, dir_tbl[k].idx,
                     dir_tbl[k].lst);
      if (dir_tbl[k].exp_prec >= 0) begin
        // single-rank run: the one curve item is read straight off the row
        void'(curve_q.pop_back());
        typed.rank = '0;
        typed.prec = 17'(dir_tbl[k].exp_prec);
        typed.lst  = 1'b1;
        curve_q = {curve_q, typed};
      end
    end
    drain();

    // random runs: each a well-formed set with random content
    for (int r = 0; r < 16; r++) begin
      case (r % 4)
        0: np = 1;
        1: np = 64;
        default: np = $urandom_range(0, 127);
      endcase
      write_num_points(7'(np));
      len = $urandom_range(2, 18);
      for (int k = 0; k < len; k++) begin
        s = rand_score();
        send_detection(s, 1'($urandom_range(0, 1)), 6'($urandom), k == len - 1);
      end
      if (r == 8) begin
        drain();  // sender holds until the curve has fully drained
      end
      drain();
    end

    drain();
    idle_cycles(50);
    if (!failed && curve_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
